/* src/arx_multi_key_hash_defines.svh */
// Assertion macros for the hash unit checker
`ifndef ARX_MULTI_KEY_HASH_DEFINES_SVH
`define ARX_MULTI_KEY_HASH_DEFINES_SVH

// clocked assertion, quiet while reset is held
`define ARXMK_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also runs through reset
`define ARXMK_ASSERT_NORST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* src/arxmk_pkg.sv */
// Types, constants and the mixing step of the ARX multi-key hash
package arxmk_pkg;

  typedef logic [63:0] word_t;

  typedef enum logic [1:0] {
    CMD_ONE   = 2'd0,
    CMD_TWO   = 2'd1,
    CMD_THREE = 2'd2,
    CMD_WIDE  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    SEL_A = 2'd0,
    SEL_B = 2'd1,
    SEL_C = 2'd2
  } word_sel_t;

  typedef struct packed {
    cmd_t  cmd;
    word_t a;
    word_t b;
    word_t c;
  } mix_t;

  localparam word_t MUL_A = 64'hff51afd7ed558ccd;
  localparam word_t MUL_B = 64'hc4ceb9fe1a85ec53;
  localparam word_t MUL_C = 64'h9e3779b97f4a7c15;

  localparam word_t XA0 = 64'h00000000cafebabe;
  localparam word_t XB0 = 64'h00000000deadbeef;
  localparam word_t XC0 = 64'h000000000b5e55ed;
  localparam word_t XA1 = 64'h00000000cabba6e5;
  localparam word_t XB1 = 64'h00000000b01dface;
  localparam word_t XA2 = 64'h00000000ba5eba11;
  localparam word_t XB2 = 64'h000000006a5f1e1d;
  localparam word_t XC2 = 64'h00000000dead50fa;

  localparam int ROUNDS    = 3;
  localparam int MIX_STEPS = 3 * ROUNDS;
  localparam int ST_IN     = 0;
  localparam int ST_MUL    = 1;
  localparam int ST_INIT   = 2;
  localparam int ST_MIX0   = 3;
  localparam int ST_OUT    = ST_MIX0 + MIX_STEPS;
  localparam int NSTAGE    = ST_OUT + 1;

  function automatic logic is_three(input cmd_t cmd);
    return (cmd == CMD_THREE) || (cmd == CMD_WIDE);
  endfunction

  // one word update: xor with constants, add (three-way in three-word modes), rotate left
  function automatic word_t mix_word(input word_sel_t sel, input logic three,
                                     input word_t a, input word_t b, input word_t c);
    word_t xa;
    word_t xb;
    word_t xc;
    word_t sum;
    word_t res;
    unique case (sel)
      SEL_A: begin
        xa = XA0; xb = XB0; xc = XC0;
      end
      SEL_B: begin
        xa = XA1; xb = XB1; xc = XC0;
      end
      default: begin
        xa = XA2; xb = XB2; xc = XC2;
      end
    endcase
    sum = (a ^ xa) + (b ^ xb) + (three ? (c ^ xc) : '0);
    unique case (sel)
      SEL_A:   res = {sum[40:0], sum[63:41]};
      SEL_B:   res = {sum[58:0], sum[63:59]};
      default: res = {sum[46:0], sum[63:47]};
    endcase
    return res;
  endfunction

endpackage

/* src/arxmk_cmul.sv */
// 64-bit multiply by a constant modulo 2^64, split into registered 32x32 partial products
module arxmk_cmul import arxmk_pkg::*; (
  input  logic  clk,
  input  logic  ld,
  input  word_t key,
  input  word_t mconst,
  output word_t prod
);

  logic [63:0] pll_r;
  logic [31:0] plh_r;
  logic [31:0] phl_r;
  logic [63:0] pll_nxt;
  logic [31:0] plh_nxt;
  logic [31:0] phl_nxt;
  logic [31:0] cross_sum;

  assign pll_nxt = {32'b0, key[31:0]} * {32'b0, mconst[31:0]};
  assign plh_nxt = key[31:0] * mconst[63:32];
  assign phl_nxt = key[63:32] * mconst[31:0];

  always_ff @(posedge clk) begin
    if (ld) begin
      pll_r <= pll_nxt;
      plh_r <= plh_nxt;
      phl_r <= phl_nxt;
    end
  end

  // high-by-high term falls off the top of a 64-bit result
  assign cross_sum = plh_r + phl_r;
  assign prod      = pll_r + {cross_sum, 32'b0};

endmodule

/* src/arxmk_mix_stage.sv */
// One registered word update of the ARX mixing rounds
module arxmk_mix_stage import arxmk_pkg::*; (
  input  logic      clk,
  input  logic      ld,
  input  word_sel_t sel,
  input  mix_t      d,
  output mix_t      q
);

  mix_t  q_r;
  mix_t  q_nxt;
  logic  three;
  word_t upd;

  assign three = is_three(d.cmd);
  assign upd   = mix_word(sel, three, d.a, d.b, d.c);

  always_comb begin
    q_nxt = d;
    unique case (sel)
      SEL_A: q_nxt.a = upd;
      SEL_B: q_nxt.b = upd;
      SEL_C: begin
        // two-word modes never touch c
        if (three) begin
          q_nxt.c = upd;
        end
      end
      default: q_nxt = d;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      q_r <= q_nxt;
    end
  end

  assign q = q_r;

endmodule

/* src/arx_multi_key_hash.sv */
// ARX multi-key hash: top level with the stage pipeline and flow control.
// Throughput: one beat per cycle while the output is not stalled; the 13-stage pipeline (input reg,
// multiply, key setup, nine one-word mixing steps, output reg) collapses bubbles under stall.
// Reset clears only the stage valid bits; the pipeline is empty and ready after it.
module arx_multi_key_hash import arxmk_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_cmd,
  input  logic [63:0] in_key_a,
  input  logic [63:0] in_key_b,
  input  logic [63:0] in_key_c,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_word0,
  output logic [63:0] out_word1,
  output logic [63:0] out_word2
);

  logic [NSTAGE-1:0] v_r;
  logic [NSTAGE-1:0] v_nxt;
  logic [NSTAGE-1:0] rdy;
  logic [NSTAGE-1:0] vin;
  logic [NSTAGE-1:0] ld;

  mix_t  s0_r;
  cmd_t  cmd1_r;
  word_t keya1_r;
  word_t prod_a;
  word_t prod_b;
  word_t prod_c;
  mix_t  s2_r;
  mix_t  s2_nxt;
  mix_t  mix_q [MIX_STEPS+1];
  word_t word0_r;
  word_t word1_r;
  word_t word2_r;
  word_t word0_nxt;
  word_t word1_nxt;
  word_t word2_nxt;

  // ready ripples back from the output; a stage moves when empty or drained
  always_comb begin
    rdy[NSTAGE-1] = !v_r[NSTAGE-1] || !out_stall;
    for (int i = NSTAGE - 2; i >= 0; i--) begin
      rdy[i] = !v_r[i] || rdy[i+1];
    end
  end

  assign vin   = {v_r[NSTAGE-2:0], in_valid};
  assign ld    = rdy & vin;
  assign v_nxt = (rdy & vin) | (~rdy & v_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_stall = !rdy[ST_IN];

  // input register
  always_ff @(posedge clk) begin
    if (ld[ST_IN]) begin
      s0_r.cmd <= cmd_t'(in_cmd);
      s0_r.a   <= in_key_a;
      s0_r.b   <= in_key_b;
      s0_r.c   <= in_key_c;
    end
  end

  // partial products
  arxmk_cmul u_mul_a (
    .clk    (clk),
    .ld     (ld[ST_MUL]),
    .key    (s0_r.a),
    .mconst (MUL_A),
    .prod   (prod_a)
  );

  arxmk_cmul u_mul_b (
    .clk    (clk),
    .ld     (ld[ST_MUL]),
    .key    (s0_r.b),
    .mconst (MUL_B),
    .prod   (prod_b)
  );

  arxmk_cmul u_mul_c (
    .clk    (clk),
    .ld     (ld[ST_MUL]),
    .key    (s0_r.c),
    .mconst (MUL_C),
    .prod   (prod_c)
  );

  always_ff @(posedge clk) begin
    if (ld[ST_MUL]) begin
      cmd1_r  <= s0_r.cmd;
      keya1_r <= s0_r.a;
    end
  end

  // working words per mode
  always_comb begin
    s2_nxt.cmd = cmd1_r;
    unique case (cmd1_r)
      CMD_ONE: begin
        s2_nxt.a = keya1_r;
        s2_nxt.b = prod_a;
        s2_nxt.c = '0;
      end
      CMD_TWO: begin
        s2_nxt.a = prod_a;
        s2_nxt.b = prod_b;
        s2_nxt.c = '0;
      end
      CMD_THREE: begin
        s2_nxt.a = prod_a;
        s2_nxt.b = prod_b;
        s2_nxt.c = prod_c;
      end
      default: begin
        s2_nxt.a = keya1_r;
        s2_nxt.b = keya1_r;
        s2_nxt.c = prod_a;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ld[ST_INIT]) begin
      s2_r <= s2_nxt;
    end
  end

  assign mix_q[0] = s2_r;

  for (genvar j = 0; j < MIX_STEPS; j++) begin : g_mix
    arxmk_mix_stage u_step (
      .clk (clk),
      .ld  (ld[ST_MIX0+j]),
      .sel (word_sel_t'(2'(j % 3))),
      .d   (mix_q[j]),
      .q   (mix_q[j+1])
    );
  end

  // fold to the result beat
  always_comb begin
    word1_nxt = '0;
    word2_nxt = '0;
    unique case (mix_q[MIX_STEPS].cmd)
      CMD_ONE, CMD_TWO: begin
        word0_nxt = mix_q[MIX_STEPS].a ^ mix_q[MIX_STEPS].b;
      end
      CMD_THREE: begin
        word0_nxt = mix_q[MIX_STEPS].a ^ mix_q[MIX_STEPS].b ^ mix_q[MIX_STEPS].c;
      end
      default: begin
        word0_nxt = mix_q[MIX_STEPS].a;
        word1_nxt = mix_q[MIX_STEPS].b;
        word2_nxt = mix_q[MIX_STEPS].c;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ld[ST_OUT]) begin
      word0_r <= word0_nxt;
      word1_r <= word1_nxt;
      word2_r <= word2_nxt;
    end
  end

  assign out_valid = v_r[ST_OUT];
  assign out_word0 = word0_r;
  assign out_word1 = word1_r;
  assign out_word2 = word2_r;

endmodule

/* src/arxmk_checker.sv */
// Port-level checker for the ARX multi-key hash, bound to the top level
`include "arx_multi_key_hash_defines.svh"

module arxmk_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic [1:0]  in_cmd,
  input logic [63:0] in_key_a,
  input logic [63:0] in_key_b,
  input logic [63:0] in_key_c,
  input logic        out_valid,
  input logic        out_stall,
  input logic [63:0] out_word0,
  input logic [63:0] out_word1,
  input logic [63:0] out_word2
);

  // a stalled result beat holds
  `ARXMK_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_word0) && $stable(out_word1) && $stable(out_word2), "result beat changed under stall")

  // result valid drops only after the beat was taken
  `ARXMK_ASSERT(a_out_drop, $fell(out_valid) |-> $past(!out_stall), "result beat dropped without handshake")

  // an open output means every stage can move, so the input never stalls
  `ARXMK_ASSERT(a_no_stall, !out_stall |-> !in_stall, "input stalled while output is open")

  // the pipeline comes out of reset empty and ready
  `ARXMK_ASSERT_NORST(a_rst_empty, rst_n && $past(!rst_n) |-> !out_valid && !in_stall, "pipeline not empty after reset")

endmodule

bind arx_multi_key_hash arxmk_checker u_arxmk_checker (.*);

/* sim/tb.sv */
// Self-checking testbench for the ARX multi-key hash unit
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import arxmk_pkg::*;

  localparam int          N_DIR      = 20;
  localparam int          N_RANDOM   = 1430;
  localparam int          HOLD_AT    = 400;
  localparam int          HOLD_LEN   = 60;
  localparam int          DRAIN      = 30;
  localparam int          WATCHDOG   = 1000;
  localparam int          MAX_REPORT = 10;
  localparam word_t       ALL_ONES   = '1;
  localparam word_t       MSB_ONLY   = 64'h8000_0000_0000_0000;
  localparam word_t       ALT_A      = 64'haaaa_aaaa_aaaa_aaaa;
  localparam word_t       ALT_5      = 64'h5555_5555_5555_5555;
  localparam int unsigned ROT_A      = 23;
  localparam int unsigned ROT_B      = 5;
  localparam int unsigned ROT_C      = 17;

  typedef struct packed {
    word_t w0;
    word_t w1;
    word_t w2;
  } hash_out_t;

  typedef struct {
    cmd_t  cmd;
    word_t ka;
    word_t kb;
    word_t kc;
    bit    typed;
    word_t w1;
    word_t w2;
  } dir_row_t;

  logic        clk;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  logic [1:0]  in_cmd    = '0;
  logic [63:0] in_key_a  = '0;
  logic [63:0] in_key_b  = '0;
  logic [63:0] in_key_c  = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [63:0] out_word0;
  logic [63:0] out_word1;
  logic [63:0] out_word2;

  hash_out_t   expected_hash[$];
  int          mismatch_count = 0;
  int          beats_in       = 0;
  int          idle_cycles    = 0;
  bit          stim_done      = 1'b0;
  bit          flood          = 1'b0;
  dir_row_t    dir_rows[N_DIR];

  arx_multi_key_hash DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_cmd    (in_cmd),
    .in_key_a  (in_key_a),
    .in_key_b  (in_key_b),
    .in_key_c  (in_key_c),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word0 (out_word0),
    .out_word1 (out_word1),
    .out_word2 (out_word2)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
  end

  function automatic word_t rol(input word_t v, input int unsigned s);
    return (v << s) | (v >> (64 - s));
  endfunction

  function automatic hash_out_t hash_predict(input cmd_t cmd, input word_t ka,
                                             input word_t kb, input word_t kc);
    word_t     a;
    word_t     b;
    word_t     c;
    hash_out_t res;
    res = '0;
    a = ka;
    b = kb;
    c = kc;
    case (cmd)
      CMD_ONE: b = ka * MUL_A;
      CMD_TWO: begin
        a = ka * MUL_A;
        b = kb * MUL_B;
      end
      CMD_THREE: begin
        a = ka * MUL_A;
        b = kb * MUL_B;
        c = kc * MUL_C;
      end
      default: begin
        b = ka;
        c = ka * MUL_A;
      end
    endcase
    for (int rnd = 0; rnd < ROUNDS; rnd++) begin
      if (cmd == CMD_ONE || cmd == CMD_TWO) begin
        a = rol((a ^ XA0) + (b ^ XB0), ROT_A);
        b = rol((a ^ XA1) + (b ^ XB1), ROT_B);
      end else begin
        a = rol((a ^ XA0) + (b ^ XB0) + (c ^ XC0), ROT_A);
        b = rol((a ^ XA1) + (b ^ XB1) + (c ^ XC0), ROT_B);
        c = rol((a ^ XA2) + (b ^ XB2) + (c ^ XC2), ROT_C);
      end
    end
    case (cmd)
      CMD_ONE, CMD_TWO: res.w0 = a ^ b;
      CMD_THREE:        res.w0 = a ^ b ^ c;
      default: begin
        res.w0 = a;
        res.w1 = b;
        res.w2 = c;
      end
    endcase
    return res;
  endfunction

  // corner values show up often, the rest is uniform
  function automatic word_t rand_key();
    word_t k;
    case ($urandom_range(0, 15))
      0:       k = '0;
      1:       k = ALL_ONES;
      2:       k = word_t'(1) << $urandom_range(0, 63);
      3:       k = ~(word_t'(1) << $urandom_range(0, 63));
      default: k = {$urandom, $urandom};
    endcase
    return k;
  endfunction

  // every fourth window of 150 beats runs with no idling on either side
  function automatic int unsigned idle_len(input bit no_gaps);
    int unsigned r;
    if (no_gaps || ((beats_in / 150) % 4 == 2))
      return 0;
    r = $urandom_range(0, 99);
    if (r < 65)
      return 0;
    if (r < 93)
      return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  function automatic void note_error(input string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORT)
      $display("%0t ERROR: %s", $realtime, msg);
  endfunction

  task automatic offer_beat(input cmd_t cmd, input word_t ka, input word_t kb,
                            input word_t kc, input hash_out_t want);
    int unsigned gap;
    gap = idle_len(flood);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd   <= cmd;
    in_key_a <= ka;
    in_key_b <= kb;
    in_key_c <= kc;
    do @(posedge clk); while (in_stall);
    expected_hash.push_back(want);
    beats_in++;
  endtask

  initial begin : drive_inputs
    hash_out_t want;
    cmd_t      cmd;
    word_t     ka;
    word_t     kb;
    word_t     kc;
    // modes 0-2 leave the upper result words at zero; unused keys must not matter
    dir_rows = '{
      '{CMD_ONE,   '0,        '0,       '0,       1'b1, '0, '0},
      '{CMD_ONE,   ALL_ONES,  ALL_ONES, ALL_ONES, 1'b1, '0, '0},
      '{CMD_ONE,   64'd1,     ALT_5,    ALT_A,    1'b1, '0, '0},
      '{CMD_ONE,   MSB_ONLY,  '0,       '0,       1'b1, '0, '0},
      '{CMD_TWO,   '0,        '0,       '0,       1'b1, '0, '0},
      '{CMD_TWO,   ALL_ONES,  ALL_ONES, '0,       1'b1, '0, '0},
      '{CMD_TWO,   '0,        ALL_ONES, ALL_ONES, 1'b1, '0, '0},
      '{CMD_TWO,   MSB_ONLY,  64'd1,    ALL_ONES, 1'b1, '0, '0},
      '{CMD_TWO,   ALT_A,     ALT_5,    64'h1234, 1'b1, '0, '0},
      '{CMD_THREE, '0,        '0,       '0,       1'b1, '0, '0},
      '{CMD_THREE, ALL_ONES,  ALL_ONES, ALL_ONES, 1'b1, '0, '0},
      '{CMD_THREE, 64'd1,     MSB_ONLY, ~MSB_ONLY, 1'b1, '0, '0},
      '{CMD_THREE, ALT_5,     ALT_A,    ALT_5,    1'b1, '0, '0},
      '{CMD_THREE, '0,        '0,       ALL_ONES, 1'b1, '0, '0},
      '{CMD_WIDE,  '0,        '0,       '0,       1'b0, '0, '0},
      '{CMD_WIDE,  ALL_ONES,  '0,       '0,       1'b0, '0, '0},
      '{CMD_WIDE,  ALL_ONES,  ALL_ONES, ALL_ONES, 1'b0, '0, '0},
      '{CMD_WIDE,  64'd1,     ALT_A,    ALT_5,    1'b0, '0, '0},
      '{CMD_WIDE,  MSB_ONLY,  64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210,
        1'b0, '0, '0},
      '{CMD_WIDE,  ~MSB_ONLY, '0,       '0,       1'b0, '0, '0}
    };
    while (!rst_n) @(posedge clk);
    for (int i = 0; i < N_DIR; i++) begin
      want = hash_predict(dir_rows[i].cmd, dir_rows[i].ka, dir_rows[i].kb, dir_rows[i].kc);
      if (dir_rows[i].typed) begin
        want.w1 = dir_rows[i].w1;
        want.w2 = dir_rows[i].w2;
      end
      offer_beat(dir_rows[i].cmd, dir_rows[i].ka, dir_rows[i].kb, dir_rows[i].kc, want);
    end
    for (int i = 0; i < N_RANDOM; i++) begin
      cmd = cmd_t'($urandom_range(0, 3));
      ka  = rand_key();
      kb  = rand_key();
      kc  = rand_key();
      offer_beat(cmd, ka, kb, kc, hash_predict(cmd, ka, kb, kc));
    end
    in_valid  <= 1'b0;
    stim_done = 1'b1;
  end

  initial begin : drive_out_stall
    int unsigned n;
    bit          held;
    held = 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      // one long hold-off while the sender keeps pushing, so the pipe backs up
      if (!held && beats_in >= HOLD_AT) begin
        held      = 1'b1;
        flood     = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_LEN) @(posedge clk);
        flood     = 1'b0;
      end
      n = idle_len(1'b0);
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
    end
  end

  always @(posedge clk) begin
    hash_out_t got;
    hash_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      got = {out_word0, out_word1, out_word2};
      if (expected_hash.size() == 0) begin
        note_error($sformatf("result beat with none expected: %h %h %h",
                             got.w0, got.w1, got.w2));
      end else begin
        want = expected_hash.pop_front();
        if (got.w0 != want.w0)
          note_error($sformatf("word0 exp %h got %h", want.w0, got.w0));
        if (got.w1 != want.w1)
          note_error($sformatf("word1 exp %h got %h", want.w1, got.w1));
        if (got.w2 != want.w2)
          note_error($sformatf("word2 exp %h got %h", want.w2, got.w2));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin : finish_run
    while (!stim_done) @(posedge clk);
    while (expected_hash.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (mismatch_count == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

/* files.f */
+incdir+src
src/arxmk_pkg.sv
src/arxmk_cmul.sv
src/arxmk_mix_stage.sv
src/arx_multi_key_hash.sv
src/arxmk_checker.sv
sim/tb.sv
